// ----- sv/cau_pkg.sv -----
// ============================================================================
// Complex arithmetic unit package
// Shared widths, opcodes, word types and saturation helpers.
// ============================================================================
`default_nettype none

package cau_pkg;

  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int ProdW = 2 * DataW;
  localparam int SumW  = ProdW + 1;
  localparam int NumW  = ProdW + FracW;
  localparam int QW    = DataW + 1;
  localparam int RemW  = ProdW;
  localparam int PreW  = NumW - QW;

  typedef enum logic [2:0] {
    OpAdd   = 3'd0,
    OpSub   = 3'd1,
    OpMul   = 3'd2,
    OpDiv   = 3'd3,
    OpScale = 3'd4,
    OpScIm  = 3'd5,
    OpConj  = 3'd6,
    OpMag2  = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0]              opcode;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
    logic signed [DataW-1:0] factor;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_re;
    logic signed [DataW-1:0] out_im;
    logic                    overflow;
    logic                    div_by_zero;
  } out_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [DataW-1:0] val;
  } sat_t;

  // Word travelling along the division chain; lane 0 is real, lane 1 imaginary.
  typedef struct packed {
    logic                    is_div;
    logic                    dz;
    logic                    ovf;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic [1:0]              neg;
    logic [1:0]              big;
    logic [ProdW-1:0]        den;
    logic [1:0][RemW-1:0]    rem;
    logic [1:0][QW-1:0]      nq;
  } cell_t;

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  function automatic logic signed [SumW-1:0] ext_prod(logic signed [ProdW-1:0] v);
    return $signed({v[ProdW-1], v});
  endfunction

  function automatic logic signed [SumW-1:0] ext_data(logic signed [DataW-1:0] v);
    return $signed({{(SumW-DataW){v[DataW-1]}}, v});
  endfunction

  function automatic sat_t sat_wide(logic signed [SumW-1:0] v);
    sat_t r;
    logic [SumW-DataW:0] hi;
    hi = v[SumW-1:DataW-1];
    if ((&hi) || !(|hi)) begin
      r.ovf = 1'b0;
      r.val = v[DataW-1:0];
    end else begin
      r.ovf = 1'b1;
      r.val = v[SumW-1] ? MinVal : MaxVal;
    end
    return r;
  endfunction

  // Applies the sign to a quotient magnitude and saturates it.
  function automatic sat_t sat_quot(logic [QW-1:0] q, logic neg, logic big);
    sat_t r;
    if (!neg) begin
      r.ovf = big | q[QW-1] | q[DataW-1];
      r.val = r.ovf ? MaxVal : $signed(q[DataW-1:0]);
    end else begin
      r.ovf = big | q[QW-1] | (q[DataW-1] & (|q[DataW-2:0]));
      r.val = r.ovf ? MinVal : $signed(-q[DataW-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cau_front.sv -----
// ============================================================================
// Complex arithmetic unit front end
// Multiplies, sums, saturates the direct results and prepares the divider.
// ============================================================================
`default_nettype none

module cau_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire cau_pkg::in_t  item_i,
  output logic               valid_o,
  output cau_pkg::cell_t     cell_o
);

  // Stage one: six products.
  logic                              s1_valid_q;
  cau_pkg::in_t                      s1_item_q;
  logic signed [cau_pkg::ProdW-1:0]  m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [cau_pkg::DataW-1:0]  x0, x1;

  always_comb begin
    x0 = item_i.b_re;
    x1 = item_i.b_im;
    case (cau_pkg::op_e'(item_i.opcode))
      cau_pkg::OpScale, cau_pkg::OpScIm: begin
        x0 = item_i.factor;
        x1 = item_i.factor;
      end
      cau_pkg::OpMag2: begin
        x0 = item_i.a_re;
        x1 = item_i.a_im;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= item_i;
    m0_q      <= item_i.a_re * x0;
    m1_q      <= item_i.a_im * x1;
    m2_q      <= item_i.a_re * item_i.b_im;
    m3_q      <= item_i.a_im * item_i.b_re;
    m4_q      <= item_i.b_re * item_i.b_re;
    m5_q      <= item_i.b_im * item_i.b_im;
  end

  // Stage two: sums and direct results.
  logic signed [cau_pkg::SumW-1:0] re_w, im_w, nre_w, nim_w, den_w;
  logic [cau_pkg::SumW-1:0]        mre_w, mim_w;
  cau_pkg::sat_t                   sre, sim;
  logic                            is_div;

  logic                            s2_valid_q;
  logic                            s2_div_q, s2_dz_q, s2_ovf_q;
  logic signed [cau_pkg::DataW-1:0] s2_re_q, s2_im_q;
  logic [1:0]                      s2_neg_q;
  logic [1:0][cau_pkg::ProdW-1:0]  s2_mag_q;
  logic [cau_pkg::ProdW-1:0]       s2_den_q;

  always_comb begin
    re_w = '0;
    im_w = '0;
    case (cau_pkg::op_e'(s1_item_q.opcode))
      cau_pkg::OpAdd: begin
        re_w = cau_pkg::ext_data(s1_item_q.a_re) + cau_pkg::ext_data(s1_item_q.b_re);
        im_w = cau_pkg::ext_data(s1_item_q.a_im) + cau_pkg::ext_data(s1_item_q.b_im);
      end
      cau_pkg::OpSub: begin
        re_w = cau_pkg::ext_data(s1_item_q.a_re) - cau_pkg::ext_data(s1_item_q.b_re);
        im_w = cau_pkg::ext_data(s1_item_q.a_im) - cau_pkg::ext_data(s1_item_q.b_im);
      end
      cau_pkg::OpMul: begin
        re_w = (cau_pkg::ext_prod(m0_q) - cau_pkg::ext_prod(m1_q)) >>> cau_pkg::FracW;
        im_w = (cau_pkg::ext_prod(m2_q) + cau_pkg::ext_prod(m3_q)) >>> cau_pkg::FracW;
      end
      cau_pkg::OpScale: begin
        re_w = cau_pkg::ext_prod(m0_q) >>> cau_pkg::FracW;
        im_w = cau_pkg::ext_prod(m1_q) >>> cau_pkg::FracW;
      end
      cau_pkg::OpScIm: begin
        re_w = cau_pkg::ext_data(s1_item_q.a_re);
        im_w = cau_pkg::ext_prod(m1_q) >>> cau_pkg::FracW;
      end
      cau_pkg::OpConj: begin
        re_w = cau_pkg::ext_data(s1_item_q.a_re);
        im_w = -cau_pkg::ext_data(s1_item_q.a_im);
      end
      cau_pkg::OpMag2: begin
        re_w = (cau_pkg::ext_prod(m0_q) + cau_pkg::ext_prod(m1_q)) >>> cau_pkg::FracW;
      end
      default: begin
      end
    endcase
    nre_w  = cau_pkg::ext_prod(m0_q) + cau_pkg::ext_prod(m1_q);
    nim_w  = cau_pkg::ext_prod(m3_q) - cau_pkg::ext_prod(m2_q);
    den_w  = cau_pkg::ext_prod(m4_q) + cau_pkg::ext_prod(m5_q);
    mre_w  = nre_w[cau_pkg::SumW-1] ? -nre_w : nre_w;
    mim_w  = nim_w[cau_pkg::SumW-1] ? -nim_w : nim_w;
    sre    = cau_pkg::sat_wide(re_w);
    sim    = cau_pkg::sat_wide(im_w);
    is_div = cau_pkg::op_e'(s1_item_q.opcode) == cau_pkg::OpDiv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_div_q    <= is_div;
    s2_dz_q     <= is_div && (den_w == '0);
    s2_ovf_q    <= sre.ovf | sim.ovf;
    s2_re_q     <= sre.val;
    s2_im_q     <= sim.val;
    s2_neg_q    <= {nim_w[cau_pkg::SumW-1], nre_w[cau_pkg::SumW-1]};
    s2_mag_q[0] <= mre_w[cau_pkg::ProdW-1:0];
    s2_mag_q[1] <= mim_w[cau_pkg::ProdW-1:0];
    s2_den_q    <= den_w[cau_pkg::ProdW-1:0];
  end

  // Stage three: a quotient of 2^QW or more is caught here; the chain then
  // works out the low QW bits.
  cau_pkg::cell_t               cell_d;
  logic [cau_pkg::NumW-1:0]     num [2];

  always_comb begin
    cell_d.is_div = s2_div_q;
    cell_d.dz     = s2_dz_q;
    cell_d.ovf    = s2_ovf_q;
    cell_d.re     = s2_re_q;
    cell_d.im     = s2_im_q;
    cell_d.neg    = s2_neg_q;
    cell_d.den    = s2_den_q;
    for (int l = 0; l < 2; l++) begin
      num[l]         = {s2_mag_q[l], {cau_pkg::FracW{1'b0}}};
      cell_d.big[l]  = {{(cau_pkg::ProdW-cau_pkg::PreW){1'b0}},
                        num[l][cau_pkg::NumW-1:cau_pkg::QW]} >= s2_den_q;
      cell_d.rem[l]  = {{(cau_pkg::RemW-cau_pkg::PreW){1'b0}},
                        num[l][cau_pkg::NumW-1:cau_pkg::QW]};
      cell_d.nq[l]   = num[l][cau_pkg::QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_o <= cell_d;
  end

endmodule

`default_nettype wire

// ----- sv/cau_div_cell.sv -----
// ============================================================================
// Complex arithmetic unit division cell
// One restoring division step for both lanes, registered.
// ============================================================================
`default_nettype none

module cau_div_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire cau_pkg::cell_t cell_i,
  output logic                valid_o,
  output cau_pkg::cell_t      cell_o
);

  cau_pkg::cell_t               cell_d;
  logic [cau_pkg::RemW:0]       trial [2];
  logic [cau_pkg::RemW:0]       diff  [2];
  logic [1:0]                   ge;

  // The partial remainder stays below the divisor, so the shifted trial
  // value fits one bit more than the remainder.
  always_comb begin
    cell_d = cell_i;
    for (int l = 0; l < 2; l++) begin
      trial[l]      = {cell_i.rem[l], cell_i.nq[l][cau_pkg::QW-1]};
      ge[l]         = trial[l] >= {1'b0, cell_i.den};
      diff[l]       = trial[l] - {1'b0, cell_i.den};
      cell_d.rem[l] = ge[l] ? diff[l][cau_pkg::RemW-1:0] : trial[l][cau_pkg::RemW-1:0];
      cell_d.nq[l]  = {cell_i.nq[l][cau_pkg::QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_o <= cell_d;
  end

endmodule

`default_nettype wire

// ----- sv/complex_arith_unit_core.sv -----
// ============================================================================
// Complex arithmetic unit
// Pipelined complex ALU in signed Q16.16 with a chained divider.
// ============================================================================
//  Channel   Signals                     Direction  Transfer
//  command   start, busy, item_i         in         start high while busy low
//  result    done_o, result_o            out        one cycle, marked by done_o
//
//  A new word is taken in every cycle while busy is low; each result passes
//  through three front stages, one cell per quotient bit (33), and the
//  output register. The divider chain sets the depth of the pipeline.
//  busy is high during reset and the cycle after it, then stays low.
//  The receiver cannot stall, so no back-pressure exists anywhere.
// ============================================================================
`default_nettype none

module complex_arith_unit_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire cau_pkg::in_t  item_i,
  output logic               done_o,
  output cau_pkg::out_t      result_o
);

  logic busy_q;
  assign busy = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  logic            chain_valid [cau_pkg::QW+1];
  cau_pkg::cell_t  chain_cell  [cau_pkg::QW+1];

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy_q),
    .item_i  (item_i),
    .valid_o (chain_valid[0]),
    .cell_o  (chain_cell[0])
  );

  for (genvar g = 0; g < cau_pkg::QW; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .cell_i  (chain_cell[g]),
      .valid_o (chain_valid[g+1]),
      .cell_o  (chain_cell[g+1])
    );
  end

  cau_pkg::cell_t  tail;
  cau_pkg::sat_t   qre, qim;
  cau_pkg::out_t   result_d;
  logic            done_q;
  cau_pkg::out_t   result_q;

  always_comb begin
    tail = chain_cell[cau_pkg::QW];
    qre  = cau_pkg::sat_quot(tail.nq[0], tail.neg[0], tail.big[0]);
    qim  = cau_pkg::sat_quot(tail.nq[1], tail.neg[1], tail.big[1]);
    if (!tail.is_div) begin
      result_d.out_re      = tail.re;
      result_d.out_im      = tail.im;
      result_d.overflow    = tail.ovf;
      result_d.div_by_zero = 1'b0;
    end else if (tail.dz) begin
      result_d.out_re      = '0;
      result_d.out_im      = '0;
      result_d.overflow    = 1'b0;
      result_d.div_by_zero = 1'b1;
    end else begin
      result_d.out_re      = qre.val;
      result_d.out_im      = qim.val;
      result_d.overflow    = qre.ovf | qim.ovf;
      result_d.div_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[cau_pkg::QW];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.div_by_zero |->
      result_o.out_re == '0 && result_o.out_im == '0 && !result_o.overflow)
    else $error("zero divisor result is not cleared");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##(cau_pkg::QW + 4) done_o)
    else $error("result word missing after pipeline latency");

  a_ready_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("busy raised outside reset");

endmodule

`default_nettype wire

// ----- sim/complex_arith_unit_core_tb.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives command words in random bursts and predicts every result in wide
// signed arithmetic. Each strobed result is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1700;
  localparam int IdleLimit = 2000;
  localparam int DrainWait = 60;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  cau_pkg::in_t  item_i;
  logic          done_o;
  cau_pkg::out_t result_o;

  complex_arith_unit_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  cau_pkg::in_t  pending_words[$];
  cau_pkg::out_t expected_results[$];
  int   errors;
  int   words_sent;
  int   results_seen;
  int   op_count[8];
  int   dz_seen;
  int   ovf_seen;
  int   idle_cycles;
  int   burst_left;
  int   gap_left;
  bit   timed_out;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Saturates a wide value; bit 32 of the return flags a clamp.
  function automatic logic [32:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return {1'b1, cau_pkg::MaxVal};
    if (v < -128'sd2147483648) return {1'b1, cau_pkg::MinVal};
    return {1'b0, v[31:0]};
  endfunction

  function automatic cau_pkg::out_t cplx_result(cau_pkg::in_t w);
    logic signed [127:0] a, b, c, d, f, re, im, den;
    logic [32:0] sr, si;
    cau_pkg::out_t r;
    a = w.a_re;
    b = w.a_im;
    c = w.b_re;
    d = w.b_im;
    f = w.factor;
    re = '0;
    im = '0;
    r.div_by_zero = 1'b0;
    case (cau_pkg::op_e'(w.opcode))
      cau_pkg::OpAdd: begin re = a + c; im = b + d; end
      cau_pkg::OpSub: begin re = a - c; im = b - d; end
      cau_pkg::OpMul: begin
        re = (a * c - b * d) >>> cau_pkg::FracW;
        im = (a * d + b * c) >>> cau_pkg::FracW;
      end
      cau_pkg::OpDiv: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          // Signed division truncates toward zero, as the hardware does.
          re = ((a * c + b * d) <<< cau_pkg::FracW) / den;
          im = ((b * c - a * d) <<< cau_pkg::FracW) / den;
        end
      end
      cau_pkg::OpScale: begin
        re = (a * f) >>> cau_pkg::FracW;
        im = (b * f) >>> cau_pkg::FracW;
      end
      cau_pkg::OpScIm: begin re = a; im = (b * f) >>> cau_pkg::FracW; end
      cau_pkg::OpConj: begin re = a; im = -b; end
      default: begin re = (a * a + b * b) >>> cau_pkg::FracW; im = '0; end
    endcase
    sr = clamp32(re);
    si = clamp32(im);
    r.out_re = sr[31:0];
    r.out_im = si[31:0];
    r.overflow = sr[32] | si[32];
    return r;
  endfunction

  function automatic logic [31:0] rand_part();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom();
    if (sel < 8) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    if (sel == 8) return $urandom_range(0, 1) ? cau_pkg::MaxVal : cau_pkg::MinVal;
    return $urandom_range(0, 2) - 1;
  endfunction

  task automatic queue_word(cau_pkg::op_e op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi, logic [31:0] fa);
    cau_pkg::in_t w;
    w.opcode = op;
    w.a_re = ar;
    w.a_im = ai;
    w.b_re = br;
    w.b_im = bi;
    w.factor = fa;
    pending_words.push_back(w);
  endtask

  // Driver: holds a word until it is taken, and mostly idles between bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    logic         taken;
    cau_pkg::in_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_results.push_back(cplx_result(item_i));
        op_count[item_i.opcode]++;
        words_sent++;
      end
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          nxt = pending_words.pop_front();
          item_i <= nxt;
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked at once.
  always @(posedge clk_i) begin
    cau_pkg::out_t exp_r;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
      if (done_o) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, result_o);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_o.div_by_zero) dz_seen++;
          if (result_o.overflow) ovf_seen++;
          if (result_o.out_re !== exp_r.out_re) begin
            $display("%0t: out_re expected %h actual %h", $realtime,
                     exp_r.out_re, result_o.out_re);
            errors++;
          end
          if (result_o.out_im !== exp_r.out_im) begin
            $display("%0t: out_im expected %h actual %h", $realtime,
                     exp_r.out_im, result_o.out_im);
            errors++;
          end
          if (result_o.overflow !== exp_r.overflow) begin
            $display("%0t: overflow expected %b actual %b", $realtime,
                     exp_r.overflow, result_o.overflow);
            errors++;
          end
          if (result_o.div_by_zero !== exp_r.div_by_zero) begin
            $display("%0t: div_by_zero expected %b actual %b", $realtime,
                     exp_r.div_by_zero, result_o.div_by_zero);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int w;
    start = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    dz_seen = 0;
    ovf_seen = 0;
    idle_cycles = 0;
    timed_out = 1'b0;

    // Directed words: extremes for each operation and the special cases.
    queue_word(cau_pkg::OpAdd, cau_pkg::MaxVal, cau_pkg::MinVal, cau_pkg::MaxVal,
               cau_pkg::MinVal, 0);
    queue_word(cau_pkg::OpSub, cau_pkg::MinVal, cau_pkg::MaxVal, cau_pkg::MaxVal,
               cau_pkg::MinVal, 0);
    queue_word(cau_pkg::OpMul, cau_pkg::MinVal, cau_pkg::MinVal, cau_pkg::MinVal,
               cau_pkg::MinVal, 0);
    queue_word(cau_pkg::OpMul, cau_pkg::MaxVal, cau_pkg::MinVal, 32'h0001_0000,
               32'hFFFF_0000, 0);
    queue_word(cau_pkg::OpDiv, 32'h0003_0000, 32'h0004_0000, 0, 0, 0);
    queue_word(cau_pkg::OpDiv, cau_pkg::MaxVal, cau_pkg::MaxVal, 32'h0000_0001, 0, 0);
    queue_word(cau_pkg::OpDiv, cau_pkg::MinVal, cau_pkg::MaxVal, cau_pkg::MinVal,
               cau_pkg::MinVal, 0);
    queue_word(cau_pkg::OpDiv, -32'sh0007_0000, 32'h0001_0000, 32'h0002_0000,
               -32'sh0003_0000, 0);
    queue_word(cau_pkg::OpScale, cau_pkg::MinVal, cau_pkg::MaxVal, 0, 0,
               cau_pkg::MinVal);
    queue_word(cau_pkg::OpScale, 32'h0002_8000, -32'sh0001_8000, cau_pkg::MaxVal,
               cau_pkg::MaxVal, 32'hFFFF_0000);
    queue_word(cau_pkg::OpScIm, cau_pkg::MinVal, cau_pkg::MinVal, 0, 0,
               cau_pkg::MaxVal);
    queue_word(cau_pkg::OpScIm, 32'h1234_5678, 32'h0001_0000, 0, 0, 32'h0001_0000);
    queue_word(cau_pkg::OpConj, cau_pkg::MaxVal, cau_pkg::MinVal, 0, 0, 0);
    queue_word(cau_pkg::OpConj, cau_pkg::MinVal, cau_pkg::MaxVal, cau_pkg::MinVal,
               cau_pkg::MaxVal, cau_pkg::MaxVal);
    queue_word(cau_pkg::OpMag2, cau_pkg::MinVal, cau_pkg::MinVal, 0, 0, 0);
    queue_word(cau_pkg::OpMag2, -32'sh0000_0001, 32'h0000_0100, 0, 0, 0);
    queue_word(cau_pkg::OpMag2, 0, 0, cau_pkg::MaxVal, cau_pkg::MaxVal,
               cau_pkg::MaxVal);

    for (w = 0; w < NumRandom; w++) begin
      queue_word(cau_pkg::op_e'($urandom_range(0, 7)), rand_part(), rand_part(),
                 rand_part(), rand_part(), rand_part());
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || start || expected_results.size() > 0) begin
      @(posedge clk_i);
      if (idle_cycles >= IdleLimit) begin
        timed_out = 1'b1;
        break;
      end
    end
    if (timed_out) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (DrainWait) @(posedge clk_i);
      $display("Sent %0d words and checked %0d results; %0d divide-by-zero, %0d saturated.",
               words_sent, results_seen, dz_seen, ovf_seen);
      $display("Per opcode: %0d %0d %0d %0d %0d %0d %0d %0d", op_count[0], op_count[1],
               op_count[2], op_count[3], op_count[4], op_count[5], op_count[6],
               op_count[7]);
      if (errors == 0 && expected_results.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
